// ===== design/llsp_pkg.sv =====
// Package for the least-loaded server picker.
// Holds the sizes, operation and status codes, the controller types and the load report helper.
// No dependencies.
`default_nettype none

package llsp_pkg;

	localparam int SLOTS_PER_POOL = 16;
	localparam int LOAD_BITS      = 16;
	localparam int TOTAL_SLOTS    = 2 * SLOTS_PER_POOL;
	localparam int SLOT_W         = $clog2(TOTAL_SLOTS);
	localparam int PIDX_W         = (SLOTS_PER_POOL > 1) ? $clog2(SLOTS_PER_POOL) : 1;
	localparam int ID_W           = 16;
	localparam int FUNC_W         = 2;
	localparam int STATUS_W       = 2;
	localparam int REP_W          = LOAD_BITS + 16;

	localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ALLOCATE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RELEASE  = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] STS_NONPOS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} llsp_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} llsp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} llsp_sts_t;

	// Loads wider than the report field saturate at all ones.
	function automatic logic [15:0] report_load(input logic [LOAD_BITS-1:0] v);
		logic [REP_W-1:0] ext;
		ext = REP_W'(v);
		if (ext > REP_W'(16'hFFFF)) begin
			return 16'hFFFF;
		end
		return ext[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/least_loaded_server_picker_core.sv =====
// Least-loaded server picker: two pools of server slots with load counts.
// Requests register a server, allocate the least loaded one, or release one load.
// Requests enter on req_valid/req_stall; each gives one response on rsp_valid/rsp_stall
// carrying status, chosen_id and prior_load.
// A request is scanned one slot per cycle over the sixteen slots of its pool,
// then the table and the result register are updated in the finish state.
// The controller then returns to idle, and only there accepts the next request.
// req_stall is high from acceptance until the update cycle has passed.
// The result register holds a response while rsp_stall is high; the next
// request is accepted and scanned meanwhile, and its update waits until the
// held response is taken.
// Reset clears every slot (all pools empty) and drops any pending response.
// Depends on llsp_pkg, llsp_ctrl and llsp_dpath.
`default_nettype none

module least_loaded_server_picker_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [llsp_pkg::FUNC_W-1:0]   func,
	input  wire logic                          pool,
	input  wire logic [llsp_pkg::ID_W-1:0]     server_id,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [llsp_pkg::STATUS_W-1:0]      status,
	output logic [llsp_pkg::ID_W-1:0]          chosen_id,
	output logic [15:0]                        prior_load
);
	import llsp_pkg::*;

	llsp_cmd_t cmd;
	llsp_sts_t sts;

	llsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	llsp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.pool       (pool),
		.server_id  (server_id),
		.status     (status),
		.chosen_id  (chosen_id),
		.prior_load (prior_load)
	);

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while another is in work");

	// An allocate that reports a non-positive id must report id zero.
	a_nonpos_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == STS_NONPOS)) |-> (chosen_id == '0))
		else $error("non-positive status with a nonzero id");

	// A full pool reports no load.
	a_full_load: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == STS_FULL)) |-> (prior_load == '0))
		else $error("full status with a nonzero load");

endmodule

`default_nettype wire

// ===== design/llsp_ctrl.sv =====
// Controller of the least-loaded server picker: request acceptance, scan sequencing,
// commit and the response valid flag. Depends on llsp_pkg.
`default_nettype none

module llsp_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output llsp_pkg::llsp_cmd_t  cmd,
	input  wire llsp_pkg::llsp_sts_t sts
);
	import llsp_pkg::*;

	llsp_state_t state_q, state_d;
	logic        rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result register must be free, or emptied in this cycle.
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

// ===== design/llsp_dpath.sv =====
// Datapath of the least-loaded server picker: slot table, one-slot-per-cycle scan,
// table update and result register. Depends on llsp_pkg.
`default_nettype none

module llsp_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire llsp_pkg::llsp_cmd_t           cmd,
	output llsp_pkg::llsp_sts_t                sts,
	input  wire logic [llsp_pkg::FUNC_W-1:0]   func,
	input  wire logic                          pool,
	input  wire logic [llsp_pkg::ID_W-1:0]     server_id,
	output logic [llsp_pkg::STATUS_W-1:0]      status,
	output logic [llsp_pkg::ID_W-1:0]          chosen_id,
	output logic [15:0]                        prior_load
);
	import llsp_pkg::*;

	logic [TOTAL_SLOTS-1:0] valid_q;
	logic [ID_W-1:0]        server_q [TOTAL_SLOTS];
	logic [LOAD_BITS-1:0]   load_q   [TOTAL_SLOTS];

	logic [FUNC_W-1:0]    func_q;
	logic                 pool_q;
	logic [ID_W-1:0]      id_q;
	logic [PIDX_W-1:0]    cnt_q;

	logic                 match_q, free_q, best_q;
	logic [SLOT_W-1:0]    match_idx_q, free_idx_q, best_idx_q;
	logic [LOAD_BITS-1:0] match_load_q, best_load_q;
	logic [ID_W-1:0]      best_server_q;

	logic [SLOT_W-1:0]    rd_idx;
	logic                 rd_valid;
	logic [ID_W-1:0]      rd_server;
	logic [LOAD_BITS-1:0] rd_load;
	logic                 rd_better;

	logic                 wr_en, wr_new;
	logic [SLOT_W-1:0]    wr_idx;
	logic [LOAD_BITS-1:0] wr_load;
	logic [STATUS_W-1:0]  res_status;
	logic [ID_W-1:0]      res_chosen;
	logic [15:0]          res_prior;

	assign rd_idx    = pool_q ? (SLOT_W'(SLOTS_PER_POOL) + SLOT_W'(cnt_q)) : SLOT_W'(cnt_q);
	assign rd_valid  = valid_q[rd_idx];
	assign rd_server = server_q[rd_idx];
	assign rd_load   = load_q[rd_idx];
	assign rd_better = !best_q || (rd_load < best_load_q) ||
		((rd_load == best_load_q) && (rd_server < best_server_q));

	assign sts.scan_last = (cnt_q == PIDX_W'(SLOTS_PER_POOL - 1));

	// Request capture and the running scan results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			best_q  <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			best_q  <= 1'b0;
		end else if (cmd.scan) begin
			cnt_q <= cnt_q + PIDX_W'(1);
			if (rd_valid && (rd_server == id_q) && !match_q) begin
				match_q <= 1'b1;
			end
			if (!rd_valid && !free_q) begin
				free_q <= 1'b1;
			end
			if (rd_valid && rd_better) begin
				best_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			pool_q <= pool;
			id_q   <= server_id;
		end
		if (cmd.scan) begin
			if (rd_valid && (rd_server == id_q) && !match_q) begin
				match_idx_q  <= rd_idx;
				match_load_q <= rd_load;
			end
			if (!rd_valid && !free_q) begin
				free_idx_q <= rd_idx;
			end
			if (rd_valid && rd_better) begin
				best_idx_q    <= rd_idx;
				best_load_q   <= rd_load;
				best_server_q <= rd_server;
			end
		end
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_new     = 1'b0;
		wr_idx     = match_idx_q;
		wr_load    = '0;
		res_status = STS_OK;
		res_chosen = id_q;
		res_prior  = '0;
		case (func_q)
			FN_REGISTER: begin
				if (match_q) begin
					res_prior = report_load(match_load_q);
				end else if (free_q) begin
					wr_en  = 1'b1;
					wr_new = 1'b1;
					wr_idx = free_idx_q;
				end else begin
					res_status = STS_FULL;
				end
			end
			FN_ALLOCATE: begin
				if (!best_q) begin
					res_status = STS_EMPTY;
					res_chosen = '0;
				end else begin
					wr_en      = 1'b1;
					wr_idx     = best_idx_q;
					wr_load    = (best_load_q == '1) ? best_load_q
						: best_load_q + LOAD_BITS'(1);
					res_chosen = best_server_q;
					res_prior  = report_load(best_load_q);
					if (best_server_q == '0) begin
						res_status = STS_NONPOS;
					end
				end
			end
			FN_RELEASE: begin
				if (!match_q) begin
					res_status = STS_EMPTY;
				end else begin
					wr_en     = 1'b1;
					wr_idx    = match_idx_q;
					wr_load   = (match_load_q == '0) ? '0 : match_load_q - LOAD_BITS'(1);
					res_prior = report_load(match_load_q);
				end
			end
			default: begin
				// Unused operation code: the table does not change.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && wr_new) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (wr_en) begin
				load_q[wr_idx] <= wr_load;
			end
			if (wr_new) begin
				server_q[wr_idx] <= id_q;
			end
			status     <= res_status;
			chosen_id  <= res_chosen;
			prior_load <= res_prior;
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_least_loaded_server_picker_core.sv =====
// Self-checking testbench for least_loaded_server_picker_core: directed and random requests
// against a built-in slot table predictor, with random gaps and response stalls.
// Depends on llsp_pkg and the least_loaded_server_picker_core RTL.
module tb_least_loaded_server_picker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import llsp_pkg::*;

	localparam logic [FUNC_W-1:0] FN_IGNORED = 2'd3;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [STATUS_W-1:0] sts;
		logic [ID_W-1:0]     pick;
		logic [15:0]         load;
	} pick_result_t;

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                req_valid  = 1'b0;
	logic                req_stall;
	logic [FUNC_W-1:0]   func       = '0;
	logic                pool       = 1'b0;
	logic [ID_W-1:0]     server_id  = '0;
	logic                rsp_valid;
	logic                rsp_stall  = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     chosen_id;
	logic [15:0]         prior_load;

	// Shadow copy of the slot table.
	logic                 slot_used [TOTAL_SLOTS];
	logic [ID_W-1:0]      slot_id   [TOTAL_SLOTS];
	logic [LOAD_BITS-1:0] slot_cnt  [TOTAL_SLOTS];

	pick_result_t pending_picks[$];
	int mismatches  = 0;
	int cycle_count = 0;
	int stall_left  = 0;
	bit idle_gaps   = 1'b0;
	bit stall_mode  = 1'b0;

	least_loaded_server_picker_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.pool       (pool),
		.server_id  (server_id),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.chosen_id  (chosen_id),
		.prior_load (prior_load)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("least_loaded_server_picker_core verification failed");
			$finish;
		end
	end

	function automatic logic [15:0] clamp_load(input logic [LOAD_BITS-1:0] v);
		if (64'(v) > 64'hFFFF) begin
			return 16'hFFFF;
		end
		return 16'(v);
	endfunction

	// Applies one request to the shadow table and returns its response.
	function automatic pick_result_t apply_request(input logic [FUNC_W-1:0] f, input logic p,
			input logic [ID_W-1:0] id);
		pick_result_t res;
		int base, hit, best, free_slot;
		base = p ? SLOTS_PER_POOL : 0;
		hit = -1;
		best = -1;
		free_slot = -1;
		res.sts = STS_OK;
		res.pick = id;
		res.load = 16'd0;
		for (int i = base; i < base + SLOTS_PER_POOL; i++) begin
			if (slot_used[i] && slot_id[i] == id && hit < 0)
				hit = i;
			if (!slot_used[i] && free_slot < 0)
				free_slot = i;
			if (slot_used[i] && (best < 0 || slot_cnt[i] < slot_cnt[best] ||
					(slot_cnt[i] == slot_cnt[best] && slot_id[i] < slot_id[best])))
				best = i;
		end
		case (f)
			FN_REGISTER: begin
				if (hit >= 0) begin
					res.load = clamp_load(slot_cnt[hit]);
				end else if (free_slot < 0) begin
					res.sts = STS_FULL;
				end else begin
					slot_used[free_slot] = 1'b1;
					slot_id[free_slot] = id;
					slot_cnt[free_slot] = '0;
				end
			end
			FN_ALLOCATE: begin
				if (best < 0) begin
					res.sts = STS_EMPTY;
					res.pick = '0;
				end else begin
					res.pick = slot_id[best];
					res.load = clamp_load(slot_cnt[best]);
					if (slot_cnt[best] != '1)
						slot_cnt[best] = slot_cnt[best] + 1'b1;
					if (slot_id[best] == '0)
						res.sts = STS_NONPOS;
				end
			end
			FN_RELEASE: begin
				if (hit < 0) begin
					res.sts = STS_EMPTY;
				end else begin
					res.load = clamp_load(slot_cnt[hit]);
					if (slot_cnt[hit] != '0)
						slot_cnt[hit] = slot_cnt[hit] - 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Mostly short, sometimes medium, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		if (r < 93)
			return $urandom_range(3, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ID_W-1:0] pick_server_id(input logic p);
		logic [ID_W-1:0] known[$];
		int base, r;
		base = p ? SLOTS_PER_POOL : 0;
		for (int i = base; i < base + SLOTS_PER_POOL; i++) begin
			if (slot_used[i])
				known.push_back(slot_id[i]);
		end
		r = $urandom_range(0, 99);
		if (r < 60 && known.size() > 0)
			return known[$urandom_range(0, known.size() - 1)];
		if (r < 80)
			return ID_W'($urandom_range(0, 31));
		return ID_W'($urandom);
	endfunction

	task automatic send_request(input logic [FUNC_W-1:0] f, input logic p,
			input logic [ID_W-1:0] id);
		int gap;
		gap = idle_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		pool <= p;
		server_id <= id;
		pending_picks.push_back(apply_request(f, p, id));
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_picks.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_pools();
		send_request(FN_ALLOCATE, 1'b0, 16'h0000);
		send_request(FN_ALLOCATE, 1'b1, 16'hFFFF);
		send_request(FN_RELEASE, 1'b0, 16'h1234);
	endtask

	task automatic test_register_and_pick();
		send_request(FN_REGISTER, 1'b0, 16'h0000);
		send_request(FN_REGISTER, 1'b0, 16'hFFFF);
		// Both at load 0: the tie goes to id 0, which reports a non-positive pick.
		send_request(FN_ALLOCATE, 1'b0, 16'hA5A5);
		send_request(FN_ALLOCATE, 1'b0, 16'h5A5A);
		send_request(FN_REGISTER, 1'b0, 16'hFFFF);
		send_request(FN_RELEASE, 1'b0, 16'h0000);
		send_request(FN_RELEASE, 1'b0, 16'h0000);
		send_request(FN_IGNORED, 1'b1, 16'hC3C3);
	endtask

	task automatic test_pool_full();
		for (int i = 0; i < SLOTS_PER_POOL - 2; i++)
			send_request(FN_REGISTER, 1'b0, ID_W'(16'h0100 + i * 16'h0111));
		send_request(FN_REGISTER, 1'b0, 16'h7777);
	endtask

	// A lone gateway is allocated again and again, so its load climbs step by step.
	task automatic test_load_count();
		idle_gaps = 1'b0;
		stall_mode = 1'b0;
		send_request(FN_REGISTER, 1'b1, 16'h8001);
		repeat (16)
			send_request(FN_ALLOCATE, 1'b1, ID_W'($urandom));
		send_request(FN_RELEASE, 1'b1, 16'h8001);
		send_request(FN_ALLOCATE, 1'b1, 16'h0000);
		send_request(FN_ALLOCATE, 1'b1, 16'hFFFF);
	endtask

	task automatic test_random_traffic();
		int r;
		logic [FUNC_W-1:0] f;
		logic p;
		for (int blk = 0; blk < 10; blk++) begin
			idle_gaps = (blk != 0) && ($urandom_range(0, 3) != 0);
			stall_mode = (blk != 0) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < 50; n++) begin
				r = $urandom_range(0, 99);
				f = (r < 25) ? FN_REGISTER : (r < 60) ? FN_ALLOCATE :
					(r < 95) ? FN_RELEASE : FN_IGNORED;
				p = $urandom_range(0, 1);
				send_request(f, p, pick_server_id(p));
			end
			if (blk == 4)
				wait_results_drained();
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_mode && $urandom_range(0, 3) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		pick_result_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_picks.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected response: status %0d chosen_id %h prior_load %0d",
						status, chosen_id, prior_load);
				mismatches++;
			end else begin
				want = pending_picks.pop_front();
				if (status !== want.sts || chosen_id !== want.pick ||
						prior_load !== want.load) begin
					if (mismatches < 10)
						$display("mismatch: expected status %0d chosen_id %h prior_load %0d, %s %0d %h %0d",
							want.sts, want.pick, want.load, "got", status, chosen_id,
							prior_load);
					mismatches++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < TOTAL_SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_id[i] = '0;
			slot_cnt[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_pools();
		test_register_and_pick();
		test_pool_full();
		test_load_count();
		test_random_traffic();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("least_loaded_server_picker_core verification clean");
		end else begin
			$display("least_loaded_server_picker_core verification failed");
		end
		$finish;
	end

endmodule
